/* sv/chc_pkg.sv */
// Shared types, widths and the arctangent table for the compass heading block.
package chc_pkg;

  localparam int ANG_FRAC  = 20;
  localparam int TABLE_LEN = 24;
  localparam int RAW_W     = 16;
  localparam int XY_W      = 38;
  localparam int Z_W       = 28;
  localparam int A_W       = 27;
  localparam int H_W       = 29;
  localparam int RES_W     = 16;

  localparam logic [H_W-1:0]   BASE_90   = H_W'(90 * (1 << ANG_FRAC));
  localparam logic [H_W-1:0]   BASE_270  = H_W'(270 * (1 << ANG_FRAC));
  localparam logic [A_W-1:0]   ANG_MAX   = A_W'(90 * (1 << ANG_FRAC));
  localparam logic [RES_W-1:0] FULL_TURN = RES_W'(36000);
  localparam logic [RES_W-1:0] HALF_TURN = RES_W'(18000);

  // atan(2^-i) in units of 2^-20 degree, rounded to nearest.
  localparam logic signed [Z_W-1:0] ATAN_TAB [TABLE_LEN] = '{
    28'sd47185920, 28'sd27855475, 28'sd14718068, 28'sd7471121,
    28'sd3750058,  28'sd1876857,  28'sd938658,   28'sd469357,
    28'sd234682,   28'sd117342,   28'sd58671,    28'sd29335,
    28'sd14668,    28'sd7334,     28'sd3667,     28'sd1833,
    28'sd917,      28'sd458,      28'sd229,      28'sd115,
    28'sd57,       28'sd29,       28'sd14,       28'sd7
  };

  // Quadrant and special-case flags that ride alongside the rotation.
  typedef struct packed {
    logic y_zero;
    logic x_zero;
    logic x_neg;
    logic y_pos;
    logic same;
  } side_t;

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
    side_t                  side;
  } cordic_t;

endpackage

/* sv/chc_if.sv */
// Valid/ready channel interfaces for readings and headings.
interface chc_in_if;
  import chc_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [RAW_W-1:0] mag_x;
  logic signed [RAW_W-1:0] mag_y;

  modport source (output valid, output mag_x, output mag_y, input ready);
  modport sink (input valid, input mag_x, input mag_y, output ready);
endinterface

interface chc_out_if;
  import chc_pkg::*;
  logic             valid;
  logic             ready;
  logic [RES_W-1:0] heading_centideg;

  modport source (output valid, output heading_centideg, input ready);
  modport sink (input valid, input heading_centideg, output ready);
endinterface

/* sv/chc_cordic_cell.sv */
// One vectoring rotation stage of the arctangent chain, with its own valid bit.
module chc_cordic_cell
  import chc_pkg::*;
#(
  parameter int STAGE = 0
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    up_valid,
  input  cordic_t up_data,
  output logic    up_ready,
  output logic    dn_valid,
  output cordic_t dn_data,
  input  logic    dn_ready
);

  logic                   valid_r;
  cordic_t                data_r;
  cordic_t                data_nxt;
  logic signed [XY_W-1:0] x_in;
  logic signed [XY_W-1:0] y_in;
  logic signed [XY_W-1:0] dx;
  logic signed [XY_W-1:0] dy;
  logic signed [Z_W-1:0]  z_in;

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  always_comb begin
    x_in = up_data.x;
    y_in = up_data.y;
    z_in = up_data.z;
    dx   = y_in >>> STAGE;
    dy   = x_in >>> STAGE;
    data_nxt      = up_data;
    // Rotate towards the x axis: clockwise while y is still non-negative.
    if (!y_in[XY_W-1]) begin
      data_nxt.x = x_in + dx;
      data_nxt.y = y_in - dy;
      data_nxt.z = z_in + ATAN_TAB[STAGE];
    end else begin
      data_nxt.x = x_in - dx;
      data_nxt.y = y_in + dy;
      data_nxt.z = z_in - ATAN_TAB[STAGE];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

/* sv/chc_heading.sv */
// Clamps the angle, forms the heading and rounds it to centidegrees over two stages.
module chc_heading
  import chc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      up_valid,
  input  cordic_t   up_data,
  output logic      up_ready,
  chc_out_if.source out_chan
);

  logic             valid_a_r;
  logic [H_W-1:0]   h_a_r;
  logic [H_W-1:0]   h_a_nxt;
  logic             y_zero_a_r;
  logic             x_neg_a_r;
  logic             ready_b;
  logic             valid_b_r;
  logic [RES_W-1:0] res_b_r;
  logic [RES_W-1:0] res_b_nxt;
  logic [A_W-1:0]   ang;
  logic [H_W-1:0]   base;
  logic [H_W+6:0]   scaled;
  logic [RES_W-1:0] rounded;

  assign ready_b  = !valid_b_r || out_chan.ready;
  assign up_ready = !valid_a_r || ready_b;

  always_comb begin
    if (up_data.side.x_zero || up_data.z[Z_W-1]) begin
      ang = '0;
    end else if (up_data.z[A_W-1:0] > ANG_MAX) begin
      ang = ANG_MAX;
    end else begin
      ang = up_data.z[A_W-1:0];
    end
    base = up_data.side.y_pos ? BASE_90 : BASE_270;
    if (up_data.side.same) begin
      h_a_nxt = base - H_W'(ang);
    end else begin
      h_a_nxt = base + H_W'(ang);
    end
  end

  always_comb begin
    // Times 100, plus one half, then drop the fraction: rounds half up.
    scaled  = (H_W+7)'(h_a_r) * (H_W+7)'(100) + (H_W+7)'(1 << (ANG_FRAC - 1));
    rounded = scaled[ANG_FRAC +: RES_W];
    if (y_zero_a_r) begin
      res_b_nxt = x_neg_a_r ? HALF_TURN : '0;
    end else if (rounded >= FULL_TURN) begin
      res_b_nxt = '0;
    end else begin
      res_b_nxt = rounded;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_a_r <= 1'b0;
      valid_b_r <= 1'b0;
    end else begin
      if (up_ready) begin
        valid_a_r <= up_valid;
      end
      if (ready_b) begin
        valid_b_r <= valid_a_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      h_a_r      <= h_a_nxt;
      y_zero_a_r <= up_data.side.y_zero;
      x_neg_a_r  <= up_data.side.x_neg;
    end
    if (ready_b && valid_a_r) begin
      res_b_r <= res_b_nxt;
    end
  end

  assign out_chan.valid            = valid_b_r;
  assign out_chan.heading_centideg = res_b_r;

endmodule

/* sv/compass_heading_from_xy_top.sv */
// Compass heading from X/Y readings: a chain of rotation cells and a rounding tail.
// Throughput: one reading per cycle while out_chan is ready; each cell of the chain
// and each tail stage holds one reading, and any stage moves on whenever the one
// after it is free.
// Reset (synchronous, active low) clears every valid bit; data registers keep
// their contents.
module compass_heading_from_xy_top
  import chc_pkg::*;
#(
  parameter int ANGLE_STAGES = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  chc_in_if.sink    in_chan,
  chc_out_if.source out_chan
);

  localparam int N_STAGES = (ANGLE_STAGES > TABLE_LEN) ? TABLE_LEN : ANGLE_STAGES;

  logic             link_valid [N_STAGES+1];
  logic             link_ready [N_STAGES+1];
  cordic_t          link_data  [N_STAGES+1];
  logic [RAW_W:0]   abs_x;
  logic [RAW_W:0]   abs_y;
  side_t            side;

  always_comb begin
    abs_x = in_chan.mag_x[RAW_W-1] ? -{in_chan.mag_x[RAW_W-1], in_chan.mag_x}
                                   : {1'b0, in_chan.mag_x};
    abs_y = in_chan.mag_y[RAW_W-1] ? -{in_chan.mag_y[RAW_W-1], in_chan.mag_y}
                                   : {1'b0, in_chan.mag_y};
    side.y_zero = (in_chan.mag_y == '0);
    side.x_zero = (in_chan.mag_x == '0);
    side.x_neg  = in_chan.mag_x[RAW_W-1];
    side.y_pos  = !in_chan.mag_y[RAW_W-1] && !side.y_zero;
    side.same   = (!side.x_neg && !side.x_zero) == side.y_pos;
    // The rotation starts from (|Y|, |X|) scaled by 2^20, with no angle yet.
    link_data[0].x    = XY_W'({abs_y, {ANG_FRAC{1'b0}}});
    link_data[0].y    = XY_W'({abs_x, {ANG_FRAC{1'b0}}});
    link_data[0].z    = '0;
    link_data[0].side = side;
  end

  assign link_valid[0] = in_chan.valid;
  assign in_chan.ready = link_ready[0];

  for (genvar i = 0; i < N_STAGES; i++) begin : g_cell
    chc_cordic_cell #(
      .STAGE (i)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (link_valid[i]),
      .up_data  (link_data[i]),
      .up_ready (link_ready[i]),
      .dn_valid (link_valid[i+1]),
      .dn_data  (link_data[i+1]),
      .dn_ready (link_ready[i+1])
    );
  end

  chc_heading u_heading (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (link_valid[N_STAGES]),
    .up_data  (link_data[N_STAGES]),
    .up_ready (link_ready[N_STAGES]),
    .out_chan (out_chan)
  );

endmodule
